FILE: rtl/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types, constants and the BLOSUM50 substitution table for the
// global sequence aligner.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int MAX_LEN_DEF  = 32;
  localparam int RES_W        = 5;
  localparam int SCORE_W      = 12;
  localparam int GAP_W        = 5;
  localparam logic [GAP_W-1:0] GAP_RESET = 5'd8;
  localparam logic [RES_W-1:0] RES_LAST  = 5'd23;
  localparam logic [RES_W-1:0] RES_X     = 5'd22;

  typedef enum logic [1:0] {
    MV_DIAG = 2'd0,
    MV_LEFT = 2'd1,
    MV_UP   = 2'd2
  } mv_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_INIT,
    ST_ROW,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_TB_SET,
    ST_TB_CHK,
    ST_TB_WR,
    ST_OUT_SET,
    ST_OUT_RD,
    ST_OUT_ST,
    ST_OUT_EM
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic init_wr;
    logic row_start;
    logic cell_rd;
    logic cell_wr;
    logic tb_set;
    logic tb_rd;
    logic tb_push;
    logic tb_from_mem;
    logic out_set;
    logic out_rd;
    logic out_st;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic rows_done;
    logic cell_last;
    logic tb_done;
    logic tb_edge;
    logic out_last;
  } status_t;

  typedef logic signed [RES_W-1:0] sub_t;

  localparam sub_t BLOSUM50 [0:23][0:23] = '{
    '{ 5,-2,-1,-2,-1,-1,-1, 0,-2,-1,-2,-1,-1,-3,-1, 1, 0,-3,-2, 0,-2,-1,-1,-5},
    '{-2, 7,-1,-2,-4, 1, 0,-3, 0,-4,-3, 3,-2,-3,-3,-1,-1,-3,-1,-3,-1, 0,-1,-5},
    '{-1,-1, 7, 2,-2, 0, 0, 0, 1,-3,-4, 0,-2,-4,-2, 1, 0,-4,-2,-3, 4, 0,-1,-5},
    '{-2,-2, 2, 8,-4, 0, 2,-1,-1,-4,-4,-1,-4,-5,-1, 0,-1,-5,-3,-4, 5, 1,-1,-5},
    '{-1,-4,-2,-4,13,-3,-3,-3,-3,-2,-2,-3,-2,-2,-4,-1,-1,-5,-3,-1,-3,-3,-2,-5},
    '{-1, 1, 0, 0,-3, 7, 2,-2, 1,-3,-2, 2, 0,-4,-1, 0,-1,-1,-1,-3, 0, 4,-1,-5},
    '{-1, 0, 0, 2,-3, 2, 6,-3, 0,-4,-3, 1,-2,-3,-1,-1,-1,-3,-2,-3, 1, 5,-1,-5},
    '{ 0,-3, 0,-1,-3,-2,-3, 8,-2,-4,-4,-2,-3,-4,-2, 0,-2,-3,-3,-4,-1,-2,-2,-5},
    '{-2, 0, 1,-1,-3, 1, 0,-2,10,-4,-3, 0,-1,-1,-2,-1,-2,-3, 2,-4, 0, 0,-1,-5},
    '{-1,-4,-3,-4,-2,-3,-4,-4,-4, 5, 2,-3, 2, 0,-3,-3,-1,-3,-1, 4,-4,-3,-1,-5},
    '{-2,-3,-4,-4,-2,-2,-3,-4,-3, 2, 5,-3, 3, 1,-4,-3,-1,-2,-1, 1,-4,-3,-1,-5},
    '{-1, 3, 0,-1,-3, 2, 1,-2, 0,-3,-3, 6,-2,-4,-1, 0,-1,-3,-2,-3, 0, 1,-1,-5},
    '{-1,-2,-2,-4,-2, 0,-2,-3,-1, 2, 3,-2, 7, 0,-3,-2,-1,-1, 0, 1,-3,-1,-1,-5},
    '{-3,-3,-4,-5,-2,-4,-3,-4,-1, 0, 1,-4, 0, 8,-4,-3,-2, 1, 4,-1,-4,-4,-2,-5},
    '{-1,-3,-2,-1,-4,-1,-1,-2,-2,-3,-4,-1,-3,-4,10,-1,-1,-4,-3,-3,-2,-1,-2,-5},
    '{ 1,-1, 1, 0,-1, 0,-1, 0,-1,-3,-3, 0,-2,-3,-1, 5, 2,-4,-2,-2, 0, 0,-1,-5},
    '{ 0,-1, 0,-1,-1,-1,-1,-2,-2,-1,-1,-1,-1,-2,-1, 2, 5,-3,-2, 0, 0,-1, 0,-5},
    '{-3,-3,-4,-5,-5,-1,-3,-3,-3,-3,-2,-3,-1, 1,-4,-4,-3,15, 2,-3,-5,-2,-3,-5},
    '{-2,-1,-2,-3,-3,-1,-2,-3, 2,-1,-1,-2, 0, 4,-3,-2,-2, 2, 8,-1,-3,-2,-1,-5},
    '{ 0,-3,-3,-4,-1,-3,-3,-4,-4, 4, 1,-3, 1,-1,-3,-2, 0,-3,-1, 5,-4,-3,-1,-5},
    '{-2,-1, 4, 5,-3, 0, 1,-1, 0,-4,-4, 0,-3,-4,-2, 0, 0,-5,-3,-4, 5, 2,-1,-5},
    '{-1, 0, 0, 1,-3, 4, 5,-2, 0,-3,-3, 1,-1,-4,-1, 0,-1,-2,-2,-3, 2, 5,-1,-5},
    '{-1,-1,-1,-1,-2,-1,-1,-2,-1,-1,-1,-1,-1,-2,-2,-1, 0,-3,-1,-1,-1,-1,-1,-5},
    '{-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5, 1}
  };

  function automatic sub_t blosum(input logic [RES_W-1:0] a, input logic [RES_W-1:0] b);
    sub_t v;
    v = '0;
    if (a <= RES_LAST && b <= RES_LAST) begin
      v = BLOSUM50[a][b];
    end
    return v;
  endfunction

endpackage

FILE: rtl/gsa_ctrl.sv
// ----------------------------------------------------------------------------
// gsa_ctrl
// Sequencer for loading, matrix fill, traceback and column output.
// ----------------------------------------------------------------------------
module gsa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_mode,
  input  logic             in_last_residue,
  input  gsa_pkg::status_t sts,
  output gsa_pkg::cmd_t    cmd,
  output logic             busy
);

  gsa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gsa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gsa_pkg::ST_IDLE: begin
        if (start && in_mode && in_last_residue) state_nxt = gsa_pkg::ST_SETUP;
      end
      gsa_pkg::ST_SETUP:   state_nxt = gsa_pkg::ST_INIT;
      gsa_pkg::ST_INIT: begin
        if (sts.init_last) state_nxt = gsa_pkg::ST_ROW;
      end
      gsa_pkg::ST_ROW: begin
        if (sts.rows_done) state_nxt = gsa_pkg::ST_TB_SET;
        else state_nxt = gsa_pkg::ST_CELL_RD;
      end
      gsa_pkg::ST_CELL_RD: state_nxt = gsa_pkg::ST_CELL_WR;
      gsa_pkg::ST_CELL_WR: begin
        if (sts.cell_last) state_nxt = gsa_pkg::ST_ROW;
        else state_nxt = gsa_pkg::ST_CELL_RD;
      end
      gsa_pkg::ST_TB_SET:  state_nxt = gsa_pkg::ST_TB_CHK;
      gsa_pkg::ST_TB_CHK: begin
        if (sts.tb_done) state_nxt = gsa_pkg::ST_OUT_SET;
        else if (!sts.tb_edge) state_nxt = gsa_pkg::ST_TB_WR;
      end
      gsa_pkg::ST_TB_WR:   state_nxt = gsa_pkg::ST_TB_CHK;
      gsa_pkg::ST_OUT_SET: state_nxt = gsa_pkg::ST_OUT_RD;
      gsa_pkg::ST_OUT_RD:  state_nxt = gsa_pkg::ST_OUT_ST;
      gsa_pkg::ST_OUT_ST:  state_nxt = gsa_pkg::ST_OUT_EM;
      gsa_pkg::ST_OUT_EM: begin
        if (sts.out_last) state_nxt = gsa_pkg::ST_IDLE;
        else state_nxt = gsa_pkg::ST_OUT_RD;
      end
      default:             state_nxt = gsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      gsa_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      gsa_pkg::ST_SETUP:   cmd.setup = 1'b1;
      gsa_pkg::ST_INIT:    cmd.init_wr = 1'b1;
      gsa_pkg::ST_ROW:     cmd.row_start = !sts.rows_done;
      gsa_pkg::ST_CELL_RD: cmd.cell_rd = 1'b1;
      gsa_pkg::ST_CELL_WR: cmd.cell_wr = 1'b1;
      gsa_pkg::ST_TB_SET:  cmd.tb_set = 1'b1;
      gsa_pkg::ST_TB_CHK: begin
        cmd.tb_push = !sts.tb_done && sts.tb_edge;
        cmd.tb_rd   = !sts.tb_done && !sts.tb_edge;
      end
      gsa_pkg::ST_TB_WR: begin
        cmd.tb_push     = 1'b1;
        cmd.tb_from_mem = 1'b1;
      end
      gsa_pkg::ST_OUT_SET: cmd.out_set = 1'b1;
      gsa_pkg::ST_OUT_RD:  cmd.out_rd = 1'b1;
      gsa_pkg::ST_OUT_ST:  cmd.out_st = 1'b1;
      gsa_pkg::ST_OUT_EM:  cmd.emit = 1'b1;
      default:             cmd = '0;
    endcase
  end

endmodule

FILE: rtl/gsa_datapath.sv
// ----------------------------------------------------------------------------
// gsa_datapath
// Sequence stores, score row, trace pointer memory, path store and counters.
// ----------------------------------------------------------------------------
module gsa_datapath #(
  parameter int MAX_LEN = gsa_pkg::MAX_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gsa_pkg::cmd_t                       cmd,
  output gsa_pkg::status_t                    sts,
  input  logic                                in_mode,
  input  logic [gsa_pkg::RES_W-1:0]           in_residue,
  input  logic                                cfg_valid,
  input  logic [gsa_pkg::GAP_W-1:0]           cfg_gap_penalty,
  output logic [gsa_pkg::RES_W-1:0]           out_top_residue,
  output logic                                out_top_is_gap,
  output logic [gsa_pkg::RES_W-1:0]           out_bottom_residue,
  output logic                                out_bottom_is_gap,
  output logic signed [gsa_pkg::SCORE_W-1:0]  out_alignment_score,
  output logic                                out_truncated,
  output logic                                out_last_column
);

  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int TDEPTH  = MAX_LEN * MAX_LEN;
  localparam int TADDR_W = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int PDEPTH  = 2 * MAX_LEN;
  localparam int PIDX_W  = $clog2(PDEPTH);
  localparam int PLEN_W  = $clog2(PDEPTH + 1);
  localparam int SW      = gsa_pkg::SCORE_W;
  localparam int RW      = gsa_pkg::RES_W;
  localparam logic [CNT_W-1:0]   MAX_CNT  = CNT_W'(MAX_LEN);
  localparam logic [TADDR_W-1:0] ROW_STEP = TADDR_W'(MAX_LEN);

  logic [RW-1:0]         first_mem  [MAX_LEN];
  logic [RW-1:0]         second_mem [MAX_LEN];
  logic signed [SW-1:0]  row_mem    [MAX_LEN];
  gsa_pkg::mv_t          trace_mem  [TDEPTH];
  gsa_pkg::mv_t          path_mem   [PDEPTH];

  logic [gsa_pkg::GAP_W-1:0] gap_r;
  logic [CNT_W-1:0]      first_cnt_r, second_cnt_r;
  logic                  dropped_r;
  logic [CNT_W-1:0]      i_r, j_r, ti_r, tj_r, oi_r, oj_r;
  logic signed [SW-1:0]  acc_r, edge_r, diag_r, left_r, score_r;
  logic [TADDR_W-1:0]    row_base_r, nbase_r, tbase_r;
  logic [PLEN_W-1:0]     len_r;
  logic [PIDX_W-1:0]     k_r;
  logic [RW-1:0]         first_q_r, second_q_r;
  logic signed [SW-1:0]  row_q_r;
  gsa_pkg::mv_t          trace_q_r, path_q_r, mv_r;

  logic [RW-1:0]         res_clamped;
  logic signed [SW-1:0]  gap_s, sd, sl, su, best;
  gsa_pkg::mv_t          cell_mv, tb_mv;
  logic [IDX_W-1:0]      jm1;
  logic [TADDR_W-1:0]    trace_wa, trace_ra;
  gsa_pkg::sub_t         sub;

  assign res_clamped = (in_residue > gsa_pkg::RES_LAST) ? gsa_pkg::RES_X : in_residue;
  assign gap_s       = SW'(gap_r);
  assign jm1         = IDX_W'(j_r - 1'b1);
  assign sub         = gsa_pkg::blosum(first_q_r, second_q_r);
  assign sd          = diag_r + SW'(sub);
  assign sl          = row_q_r - gap_s;
  assign su          = left_r - gap_s;
  assign trace_wa    = row_base_r + TADDR_W'(j_r - 1'b1);
  assign trace_ra    = tbase_r + TADDR_W'(tj_r - 1'b1);

  always_comb begin
    if (sd >= sl && sd >= su) begin
      best = sd; cell_mv = gsa_pkg::MV_DIAG;
    end else if (sl >= su) begin
      best = sl; cell_mv = gsa_pkg::MV_LEFT;
    end else begin
      best = su; cell_mv = gsa_pkg::MV_UP;
    end
  end

  always_comb begin
    if (cmd.tb_from_mem) tb_mv = trace_q_r;
    else if (tj_r == '0) tb_mv = gsa_pkg::MV_LEFT;
    else tb_mv = gsa_pkg::MV_UP;
  end

  assign sts.init_last = (j_r == second_cnt_r);
  assign sts.rows_done = (i_r == first_cnt_r);
  assign sts.cell_last = (j_r == second_cnt_r);
  assign sts.tb_done   = (ti_r == '0) && (tj_r == '0);
  assign sts.tb_edge   = (ti_r == '0) || (tj_r == '0);
  assign sts.out_last  = (k_r == '0);

  // configuration and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r        <= gsa_pkg::GAP_RESET;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      dropped_r    <= 1'b0;
    end else begin
      if (cfg_valid) gap_r <= cfg_gap_penalty;
      if (cmd.load) begin
        if (!in_mode) begin
          if (first_cnt_r < MAX_CNT) first_cnt_r <= first_cnt_r + 1'b1;
          else dropped_r <= 1'b1;
        end else begin
          if (second_cnt_r < MAX_CNT) second_cnt_r <= second_cnt_r + 1'b1;
          else dropped_r <= 1'b1;
        end
      end
      if (cmd.emit && sts.out_last) begin
        first_cnt_r  <= '0;
        second_cnt_r <= '0;
        dropped_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !in_mode && first_cnt_r < MAX_CNT) begin
      first_mem[first_cnt_r[IDX_W-1:0]] <= res_clamped;
    end
    if (cmd.row_start) first_q_r <= first_mem[i_r[IDX_W-1:0]];
    else if (cmd.out_st) first_q_r <= first_mem[oi_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_mode && second_cnt_r < MAX_CNT) begin
      second_mem[second_cnt_r[IDX_W-1:0]] <= res_clamped;
    end
    if (cmd.cell_rd) second_q_r <= second_mem[jm1];
    else if (cmd.out_st) second_q_r <= second_mem[oj_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.init_wr) row_mem[jm1] <= acc_r;
    else if (cmd.cell_wr) row_mem[jm1] <= best;
    if (cmd.cell_rd) row_q_r <= row_mem[jm1];
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_wr) trace_mem[trace_wa] <= cell_mv;
    if (cmd.tb_rd) trace_q_r <= trace_mem[trace_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.tb_push) path_mem[len_r[PIDX_W-1:0]] <= tb_mv;
    if (cmd.out_rd) path_q_r <= path_mem[k_r];
  end

  // fill, traceback and output sequencing
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      i_r     <= '0;
      j_r     <= CNT_W'(1);
      acc_r   <= -gap_s;
      edge_r  <= '0;
      nbase_r <= '0;
    end
    if (cmd.init_wr) begin
      if (sts.init_last) score_r <= acc_r;
      acc_r <= acc_r - gap_s;
      j_r   <= j_r + 1'b1;
    end
    if (cmd.row_start) begin
      i_r        <= i_r + 1'b1;
      j_r        <= CNT_W'(1);
      diag_r     <= edge_r;
      edge_r     <= edge_r - gap_s;
      left_r     <= edge_r - gap_s;
      row_base_r <= nbase_r;
      nbase_r    <= nbase_r + ROW_STEP;
    end
    if (cmd.cell_wr) begin
      if (sts.cell_last) score_r <= best;
      diag_r <= row_q_r;
      left_r <= best;
      j_r    <= j_r + 1'b1;
    end
    if (cmd.tb_set) begin
      ti_r    <= first_cnt_r;
      tj_r    <= second_cnt_r;
      tbase_r <= row_base_r;
      len_r   <= '0;
    end
    if (cmd.tb_push) begin
      len_r <= len_r + 1'b1;
      case (tb_mv)
        gsa_pkg::MV_DIAG: begin
          ti_r <= ti_r - 1'b1; tj_r <= tj_r - 1'b1; tbase_r <= tbase_r - ROW_STEP;
        end
        gsa_pkg::MV_LEFT: begin
          ti_r <= ti_r - 1'b1; tbase_r <= tbase_r - ROW_STEP;
        end
        default: tj_r <= tj_r - 1'b1;
      endcase
    end
    if (cmd.out_set) begin
      k_r  <= PIDX_W'(len_r - 1'b1);
      oi_r <= '0;
      oj_r <= '0;
    end
    if (cmd.out_st) mv_r <= path_q_r;
    if (cmd.emit) begin
      k_r <= k_r - 1'b1;
      case (mv_r)
        gsa_pkg::MV_DIAG: begin
          oi_r <= oi_r + 1'b1; oj_r <= oj_r + 1'b1;
        end
        gsa_pkg::MV_LEFT: oi_r <= oi_r + 1'b1;
        default:          oj_r <= oj_r + 1'b1;
      endcase
    end
  end

  assign out_top_is_gap      = (mv_r == gsa_pkg::MV_UP);
  assign out_bottom_is_gap   = (mv_r == gsa_pkg::MV_LEFT);
  assign out_top_residue     = out_top_is_gap ? '0 : first_q_r;
  assign out_bottom_residue  = out_bottom_is_gap ? '0 : second_q_r;
  assign out_alignment_score = score_r;
  assign out_truncated       = dropped_r;
  assign out_last_column     = sts.out_last;

endmodule

FILE: rtl/global_sequence_aligner.sv
// ----------------------------------------------------------------------------
// global_sequence_aligner
// Needleman-Wunsch global alignment, BLOSUM50 scores, linear gap cost.
// ----------------------------------------------------------------------------
// Load: one residue per cycle, busy stays low while loading.
// Alignment: after the last residue, a setup step and the initial score row
//   writes, then per row a row start step and a read and a write step per cell
//   (on the score row memory port), then traceback, then an output setup step
//   and, per column, a path read, a residue store and the emit step.
// The receiver cannot stall; each column strobes out_valid for one cycle.
// Reset (synchronous, rst_n low) clears counts, truncation flag, gap to 8.
module global_sequence_aligner #(
  parameter int MAX_LEN = gsa_pkg::MAX_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_mode,
  input  logic [gsa_pkg::RES_W-1:0]           in_residue,
  input  logic                                in_last_residue,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gsa_pkg::GAP_W-1:0]           cfg_gap_penalty,
  output logic                                out_valid,
  output logic [gsa_pkg::RES_W-1:0]           out_top_residue,
  output logic                                out_top_is_gap,
  output logic [gsa_pkg::RES_W-1:0]           out_bottom_residue,
  output logic                                out_bottom_is_gap,
  output logic signed [gsa_pkg::SCORE_W-1:0]  out_alignment_score,
  output logic                                out_truncated,
  output logic                                out_last_column
);

  gsa_pkg::cmd_t    cmd;
  gsa_pkg::status_t sts;

  assign cfg_ready = 1'b1;
  assign out_valid = cmd.emit;

  gsa_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_mode         (in_mode),
    .in_last_residue (in_last_residue),
    .sts             (sts),
    .cmd             (cmd),
    .busy            (busy)
  );

  gsa_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_mode             (in_mode),
    .in_residue          (in_residue),
    .cfg_valid           (cfg_valid),
    .cfg_gap_penalty     (cfg_gap_penalty),
    .out_top_residue     (out_top_residue),
    .out_top_is_gap      (out_top_is_gap),
    .out_bottom_residue  (out_bottom_residue),
    .out_bottom_is_gap   (out_bottom_is_gap),
    .out_alignment_score (out_alignment_score),
    .out_truncated       (out_truncated),
    .out_last_column     (out_last_column)
  );

endmodule

FILE: rtl/gsa_checker.sv
// ----------------------------------------------------------------------------
// gsa_checker
// Port-level checks for the global sequence aligner.
// ----------------------------------------------------------------------------
module gsa_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_top_is_gap,
  input logic out_bottom_is_gap,
  input logic out_last_column
);

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while not busy");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_column |=> !busy) else $error("busy after last column");

  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_column |=> !out_valid) else $error("back to back results");

  a_gaps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_top_is_gap && out_bottom_is_gap)) else $error("double gap");

endmodule

bind global_sequence_aligner gsa_checker u_gsa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_top_is_gap    (out_top_is_gap),
  .out_bottom_is_gap (out_bottom_is_gap),
  .out_last_column   (out_last_column)
);
